// ----- rtl/core/ifsf_pkg.sv -----
// Package for the information frame stuffing framer.
// Holds the queue entry type, config struct, sequencer phases and register indexes.
// No dependencies.
package ifsf_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [7:0] FLAG_RST   = 8'h7E;
  localparam logic [7:0] ESCAPE_RST = 8'h7D;
  localparam logic [7:0] MASK_RST   = 8'h20;
  localparam logic [7:0] ADDR_RST   = 8'h03;
  localparam logic [7:0] CTRL0_RST  = 8'h00;
  localparam logic [7:0] CTRL1_RST  = 8'h40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLAG   = 3'd0,
    REG_ESCAPE = 3'd1,
    REG_MASK   = 3'd2,
    REG_ADDR   = 3'd3,
    REG_CTRL0  = 3'd4,
    REG_CTRL1  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] xor_mask;
    logic [7:0] address_byte;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  // One classified payload byte, as handed from front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;    // closes the frame
    logic       hdr;     // opens a frame, header goes first
    logic       seq;     // sequence bit, meaningful with hdr
    logic [7:0] parity;  // frame parity including this byte
  } job_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_HDR_FLAG,
    PH_HDR_ADDR,
    PH_HDR_CTRL,
    PH_HDR_CHK,
    PH_DATA,
    PH_DATA_ESC,
    PH_PAR,
    PH_PAR_ESC,
    PH_CLOSE
  } phase_e;

endpackage

// ----- rtl/core/ifsf_if.sv -----
// Stream and configuration channel interfaces of the framer.
// Valid/ready handshake; no package dependency.
interface ifsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_payload;
  logic       frame_sequence;

  modport source (output valid, data_byte, end_of_payload, frame_sequence, input ready);
  modport sink   (input valid, data_byte, end_of_payload, frame_sequence, output ready);
endinterface

interface ifsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, out_byte, run_last, frame_end, input ready);
  modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface

interface ifsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ifsf_front.sv -----
// Front end: accepts payload bytes, tracks frame state and running parity.
// Depends on ifsf_pkg.
module ifsf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_payload_i,
  input  logic                frame_sequence_i,
  output logic                push_o,
  input  logic                full_i,
  output ifsf_pkg::job_t      job_o
);
  import ifsf_pkg::*;

  logic       inside_q, inside_d;
  logic [7:0] parity_q, parity_d;
  logic [7:0] par_new;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign par_new    = (inside_q ? parity_q : 8'h00) ^ data_byte_i;

  always_comb begin
    job_o.data_byte = data_byte_i;
    job_o.last      = end_of_payload_i;
    job_o.hdr       = !inside_q;
    job_o.seq       = frame_sequence_i;
    job_o.parity    = par_new;
  end

  always_comb begin
    inside_d = inside_q;
    parity_d = parity_q;
    if (push_o) begin
      inside_d = !end_of_payload_i;
      parity_d = end_of_payload_i ? 8'h00 : par_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      parity_q <= 8'h00;
    end else begin
      inside_q <= inside_d;
      parity_q <= parity_d;
    end
  end

endmodule

// ----- rtl/core/ifsf_queue.sv -----
// Small FIFO of classified jobs between front and back.
// Depends on ifsf_pkg.
module ifsf_queue #(
  parameter int unsigned Depth = ifsf_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ifsf_pkg::job_t push_job_i,
  output logic           full_o,
  output logic           head_valid_o,
  output ifsf_pkg::job_t head_job_o,
  input  logic           pop_i
);
  import ifsf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntFull);
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/ifsf_back.sv -----
// Back end: byte sequencer for header, stuffing, parity and closing flag,
// with a registered output stage. Depends on ifsf_pkg.
module ifsf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ifsf_pkg::cfg_t cfg_i,
  input  logic           head_valid_i,
  input  ifsf_pkg::job_t head_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  output logic           frame_end_o
);
  import ifsf_pkg::*;

  phase_e     phase_q, phase_d, eff;
  logic       load;
  logic [7:0] ctrl;
  logic       d_stuff, p_stuff;
  logic [7:0] byte_c;
  logic       done_c, fend_c;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       run_last_q, frame_end_q;

  assign ctrl    = head_job_i.seq ? cfg_i.control_seq_one : cfg_i.control_seq_zero;
  assign d_stuff = (head_job_i.data_byte == cfg_i.flag_byte) ||
                   (head_job_i.data_byte == cfg_i.escape_byte);
  assign p_stuff = (head_job_i.parity == cfg_i.flag_byte) ||
                   (head_job_i.parity == cfg_i.escape_byte);
  assign eff     = (phase_q == PH_START) ? (head_job_i.hdr ? PH_HDR_FLAG : PH_DATA) : phase_q;
  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = load && done_c;

  // byte produced in the current phase
  always_comb begin
    byte_c = 8'h00;
    done_c = 1'b0;
    fend_c = 1'b0;
    unique case (eff)
      PH_HDR_FLAG: byte_c = cfg_i.flag_byte;
      PH_HDR_ADDR: byte_c = cfg_i.address_byte;
      PH_HDR_CTRL: byte_c = ctrl;
      PH_HDR_CHK:  byte_c = cfg_i.address_byte ^ ctrl;
      PH_DATA: begin
        byte_c = d_stuff ? cfg_i.escape_byte : head_job_i.data_byte;
        done_c = !d_stuff && !head_job_i.last;
      end
      PH_DATA_ESC: begin
        byte_c = head_job_i.data_byte ^ cfg_i.xor_mask;
        done_c = !head_job_i.last;
      end
      PH_PAR:     byte_c = p_stuff ? cfg_i.escape_byte : head_job_i.parity;
      PH_PAR_ESC: byte_c = head_job_i.parity ^ cfg_i.xor_mask;
      PH_CLOSE: begin
        byte_c = cfg_i.flag_byte;
        done_c = 1'b1;
        fend_c = 1'b1;
      end
      default: begin
        byte_c = 8'h00;
        done_c = 1'b0;
        fend_c = 1'b0;
      end
    endcase
  end

  // phase advance, once per loaded byte
  always_comb begin
    phase_d = phase_q;
    if (load) begin
      unique case (eff)
        PH_HDR_FLAG: phase_d = PH_HDR_ADDR;
        PH_HDR_ADDR: phase_d = PH_HDR_CTRL;
        PH_HDR_CTRL: phase_d = PH_HDR_CHK;
        PH_HDR_CHK:  phase_d = PH_DATA;
        PH_DATA: begin
          if (d_stuff) begin
            phase_d = PH_DATA_ESC;
          end else begin
            phase_d = head_job_i.last ? PH_PAR : PH_START;
          end
        end
        PH_DATA_ESC: phase_d = head_job_i.last ? PH_PAR : PH_START;
        PH_PAR:      phase_d = p_stuff ? PH_PAR_ESC : PH_CLOSE;
        PH_PAR_ESC:  phase_d = PH_CLOSE;
        default:     phase_d = PH_START;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q  <= byte_c;
      run_last_q  <= done_c;
      frame_end_q <= fend_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

endmodule

// ----- rtl/core/information_frame_stuffing_framer.sv -----
// Information frame stuffing framer, top level.
// Path: an accepted byte is written into the queue, and its first result is then
// loaded into the output register of the back end.
// Throughput: back sequencer, one line byte per cycle while line_o is ready;
// an item is 1 to 9 bytes (header 4, payload 1-2, parity 1-2, closing flag 1).
// Reset: async active low; no frame open, parity zero, registers at defaults.
module information_frame_stuffing_framer #(
  parameter int unsigned QueueDepth = ifsf_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ifsf_in_if.sink    item_i,
  ifsf_cfg_if.sink   cfg_i,
  ifsf_out_if.source line_o
);
  import ifsf_pkg::*;

  cfg_t cfg_q;
  job_t push_job, head_job;
  logic push, full, head_valid, pop;

  // Config writes are always taken; unknown indexes fall through.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte        <= FLAG_RST;
      cfg_q.escape_byte      <= ESCAPE_RST;
      cfg_q.xor_mask         <= MASK_RST;
      cfg_q.address_byte     <= ADDR_RST;
      cfg_q.control_seq_zero <= CTRL0_RST;
      cfg_q.control_seq_one  <= CTRL1_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_FLAG:   cfg_q.flag_byte        <= cfg_i.data;
        REG_ESCAPE: cfg_q.escape_byte      <= cfg_i.data;
        REG_MASK:   cfg_q.xor_mask         <= cfg_i.data;
        REG_ADDR:   cfg_q.address_byte     <= cfg_i.data;
        REG_CTRL0:  cfg_q.control_seq_zero <= cfg_i.data;
        REG_CTRL1:  cfg_q.control_seq_one  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Front: frame state and parity, one transfer per cycle while the queue has room.
  ifsf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (item_i.valid),
    .in_ready_o       (item_i.ready),
    .data_byte_i      (item_i.data_byte),
    .end_of_payload_i (item_i.end_of_payload),
    .frame_sequence_i (item_i.frame_sequence),
    .push_o           (push),
    .full_i           (full),
    .job_o            (push_job)
  );

  // Decoupling queue: the front keeps taking bytes while the back expands one.
  ifsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_job_o   (head_job),
    .pop_i        (pop)
  );

  // Back: emits header, stuffed payload, stuffed parity and closing flag.
  ifsf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (line_o.valid),
    .out_ready_i  (line_o.ready),
    .out_byte_o   (line_o.out_byte),
    .run_last_o   (line_o.run_last),
    .frame_end_o  (line_o.frame_end)
  );

endmodule
